// ===== design/opf_pkg.sv =====
// opf_pkg: shared types and constants of the outline path flattener
// no dependencies; imported by every module of the block but opf_fifo

package opf_pkg;

   typedef enum logic [1:0] {
      OP_MOVE  = 2'd0,
      OP_LINE  = 2'd1,
      OP_QUAD  = 2'd2,
      OP_CUBIC = 2'd3
   } opf_op_type;

   // side band of one point travelling down the lerp pipeline
   typedef struct packed {
      logic valid;
      logic start;
      logic last;
   } opf_tag_type;

   // lerp weights in tenths
   localparam logic [3:0] K_SCALE = 4'd10;
   localparam logic [3:0] K_EARLY = 4'd2;
   localparam logic [3:0] K_HALF  = 4'd5;
   localparam logic [3:0] K_LATE  = 4'd7;

   // register stages of one lerp unit
   localparam int LERP_STAGES = 3;

endpackage

// ===== design/opf_fifo.sv =====
// opf_fifo: small register fifo with fall-through read
// depends on nothing; used for the command queue and the point queue

module opf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== design/opf_front.sv =====
// opf_front: accepts path commands, tracks the pen, precomputes quadratic midpoints
// depends on opf_pkg; feeds the command queue

module opf_front #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [1:0]                   req_operation,
   input  logic signed [COORD_BITS-1:0] req_ctrl1_x,
   input  logic signed [COORD_BITS-1:0] req_ctrl1_y,
   input  logic signed [COORD_BITS-1:0] req_ctrl2_x,
   input  logic signed [COORD_BITS-1:0] req_ctrl2_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic                         cmd_full,
   output logic                         cmd_push,
   output logic [2+8*COORD_BITS-1:0]    cmd_data
);

   import opf_pkg::*;

   localparam int C = COORD_BITS;

   logic signed [C-1:0] pen_x_ff, pen_x_in;
   logic signed [C-1:0] pen_y_ff, pen_y_in;
   logic signed [C-1:0] mid_x, mid_y, slot1_x, slot1_y;
   opf_op_type          op;

   // (pen + 2*ctrl + end) / 4, truncated toward zero
   function automatic logic signed [C-1:0] quad_mid(logic signed [C-1:0] p0,
                                                    logic signed [C-1:0] p1,
                                                    logic signed [C-1:0] p2);
      logic signed [C+1:0] sum;
      logic signed [C+1:0] biased;
      sum    = {{2{p0[C-1]}}, p0} + {p1[C-1], p1, 1'b0} + {{2{p2[C-1]}}, p2};
      biased = sum + {{C{1'b0}}, sum[C+1], sum[C+1]};
      return biased[C+1:2];
   endfunction

   assign op       = opf_op_type'(req_operation);
   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

   assign mid_x   = quad_mid(pen_x_ff, req_ctrl1_x, req_end_x);
   assign mid_y   = quad_mid(pen_y_ff, req_ctrl1_y, req_end_y);
   // a quadratic only needs its midpoint in the first control slot
   assign slot1_x = (op == OP_QUAD) ? mid_x : req_ctrl1_x;
   assign slot1_y = (op == OP_QUAD) ? mid_y : req_ctrl1_y;

   assign cmd_data = {req_operation, pen_x_ff, pen_y_ff, slot1_x, slot1_y,
                      req_ctrl2_x, req_ctrl2_y, req_end_x, req_end_y};

   assign pen_x_in = cmd_push ? req_end_x : pen_x_ff;
   assign pen_y_in = cmd_push ? req_end_y : pen_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
      end
   end

endmodule

// ===== design/opf_lerp.sv =====
// opf_lerp: three-stage pipelined (a*(10-k) + b*k) / 10, truncated toward zero
// depends on opf_pkg; instanced by the back end

module opf_lerp #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic signed [COORD_BITS-1:0] a,
   input  logic signed [COORD_BITS-1:0] b,
   input  logic [3:0]                   k,
   output logic signed [COORD_BITS-1:0] result
);

   import opf_pkg::*;

   localparam int C = COORD_BITS;
   localparam int W = C + 4;
   localparam int M = C + 3;

   logic signed [W-1:0] a_ext, b_ext, ka_ext, kb_ext, s, s_abs;
   logic [M-1:0]        mag_ff, mag_in, mag2_ff, q_ff, q_in, r, q_fix, q_neg;
   logic                neg_ff, neg_in, neg2_ff;
   logic signed [C-1:0] result_ff, result_in;

   // stage 1: weighted sum and magnitude
   always_comb begin
      a_ext  = {{4{a[C-1]}}, a};
      b_ext  = {{4{b[C-1]}}, b};
      ka_ext = $signed({{(W-4){1'b0}}, K_SCALE - k});
      kb_ext = $signed({{(W-4){1'b0}}, k});
      s      = a_ext * ka_ext + b_ext * kb_ext;
      neg_in = s[W-1];
      s_abs  = neg_in ? -s : s;
      mag_in = s_abs[M-1:0];
   end

   // stage 2: shift-add estimate of mag / 10, at most one short
   always_comb begin
      q_in = (mag_ff >> 1) + (mag_ff >> 2);
      for (int i = 0; i < 4; i++) begin
         if ((4 << i) < M) begin
            q_in = q_in + (q_in >> (4 << i));
         end
      end
      q_in = q_in >> 3;
   end

   // stage 3: remainder correction and sign
   always_comb begin
      r         = mag2_ff - ((q_ff << 3) + (q_ff << 1));
      q_fix     = q_ff + {{(M-1){1'b0}}, (r > M'(9))};
      q_neg     = ~q_fix + 1'b1;
      result_in = neg2_ff ? q_neg[C-1:0] : q_fix[C-1:0];
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      q_ff      <= q_in;
      mag2_ff   <= mag_ff;
      neg2_ff   <= neg_ff;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== design/opf_back.sv =====
// opf_back: steps through queued commands, one point a cycle while a credit is free,
// down a de casteljau pipeline; depends on opf_pkg and opf_lerp; writes the point queue

module opf_back #(
   parameter int COORD_BITS = 24,
   parameter int OUT_DEPTH  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_empty,
   input  logic [2+8*COORD_BITS-1:0] cmd_data,
   output logic                      cmd_pop,
   input  logic                      out_pop,
   output logic                      out_push,
   output logic [2*COORD_BITS+1:0]   out_data
);

   import opf_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int OW    = $clog2(OUT_DEPTH + 1);
   localparam int DELAY = 3 * LERP_STAGES;

   opf_op_type  op;
   logic [1:0]  step_ff, step_in, last_step, flat_idx;
   logic [OW-1:0] occ_ff, occ_in;
   logic        issue, use_curve;
   logic [3:0]  k_issue;
   logic [3:0]  k_ff [2*LERP_STAGES];
   opf_tag_type tag_in;
   opf_tag_type tag_ff [DELAY];
   logic signed [C-1:0] res [2];

   assign op = opf_op_type'(cmd_data[8*C+1:8*C]);

   // credit: points in flight plus points queued never exceed the queue depth
   assign issue   = !cmd_empty && (occ_ff < OW'(OUT_DEPTH));
   assign cmd_pop = issue && (step_ff == last_step);

   always_comb begin
      last_step = 2'd0;
      use_curve = 1'b0;
      flat_idx  = 2'd3;
      k_issue   = K_HALF;
      case (op)
         OP_MOVE, OP_LINE: begin
            last_step = 2'd0;
         end
         OP_QUAD: begin
            last_step = 2'd1;
            flat_idx  = (step_ff == 2'd0) ? 2'd1 : 2'd3;
         end
         OP_CUBIC: begin
            last_step = 2'd3;
            use_curve = (step_ff != 2'd3);
            case (step_ff)
               2'd0:    k_issue = K_EARLY;
               2'd1:    k_issue = K_HALF;
               default: k_issue = K_LATE;
            endcase
         end
         default: begin
            last_step = 2'd0;
         end
      endcase
      tag_in.valid = issue;
      tag_in.start = (op == OP_MOVE);
      tag_in.last  = (step_ff == last_step);
   end

   always_comb begin
      step_in = step_ff;
      if (issue) begin
         step_in = cmd_pop ? 2'd0 : step_ff + 2'd1;
      end
      occ_in = occ_ff;
      if (issue && !out_pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (out_pop && !issue) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         occ_ff  <= '0;
         for (int i = 0; i < DELAY; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         step_ff   <= step_in;
         occ_ff    <= occ_in;
         tag_ff[0] <= tag_in;
         for (int i = 1; i < DELAY; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff[0] <= k_issue;
      for (int i = 1; i < 2*LERP_STAGES; i++) begin
         k_ff[i] <= k_ff[i-1];
      end
   end

   genvar g, j;
   generate
      for (g = 0; g < 2; g++) begin : g_axis
         logic signed [C-1:0] src [4];
         logic signed [C-1:0] sel [4];
         logic signed [C-1:0] lv1 [3];
         logic signed [C-1:0] lv2 [2];

         // point j of axis g: pen, control 1, control 2, end
         for (j = 0; j < 4; j++) begin : g_pt
            assign src[j] = cmd_data[(7-2*j-g)*C +: C];
            // a flat point is fed as four equal points, which the lerps return unchanged
            assign sel[j] = use_curve ? src[j] : src[flat_idx];
         end

         for (j = 0; j < 3; j++) begin : g_lv1
            opf_lerp #(.COORD_BITS(C)) u_lerp (
               .clock  (clock),
               .a      (sel[j]),
               .b      (sel[j+1]),
               .k      (k_issue),
               .result (lv1[j])
            );
         end

         for (j = 0; j < 2; j++) begin : g_lv2
            opf_lerp #(.COORD_BITS(C)) u_lerp (
               .clock  (clock),
               .a      (lv1[j]),
               .b      (lv1[j+1]),
               .k      (k_ff[LERP_STAGES-1]),
               .result (lv2[j])
            );
         end

         opf_lerp #(.COORD_BITS(C)) u_lv3 (
            .clock  (clock),
            .a      (lv2[0]),
            .b      (lv2[1]),
            .k      (k_ff[2*LERP_STAGES-1]),
            .result (res[g])
         );
      end
   endgenerate

   assign out_push = tag_ff[DELAY-1].valid;
   assign out_data = {tag_ff[DELAY-1].start, tag_ff[DELAY-1].last, res[0], res[1]};

endmodule

// ===== design/outline_path_flattener.sv =====
// outline_path_flattener: top level, flattens outline path commands into polyline points
// depends on opf_pkg, opf_fifo, opf_front and opf_back
//
// usage
//  - command beats go in on the req_ side: an item is taken at a rising edge with
//    req_push high and req_full low; req_operation selects move, line, quadratic, cubic
//  - point beats come out on the rsp_ side: the oldest point sits on the rsp_ ports
//    while rsp_empty is low and leaves at an edge with rsp_pop high
//  - move and line give one point, quadratic two, cubic four; rsp_last marks the
//    final point of a command, rsp_contour_start the point of a move
//  - throughput: one point per cycle while a command is queued and a credit is free;
//    the single point issue slot of the back end sets this
//  - a command goes through the command queue; its points then pass three de casteljau
//    levels of three register stages each and the point queue before showing on rsp_
//  - full rate needs OUT_DEPTH of at least 11, so that credits cover the pipeline
//  - reset (synchronous) empties both queues and sets the pen to the origin
//  - when the receiver stalls, the point queue fills, the back end stops issuing,
//    then the command queue fills and req_full rises; nothing is dropped

module outline_path_flattener #(
   parameter int COORD_BITS = 24,
   parameter int CMD_DEPTH  = 4,
   parameter int OUT_DEPTH  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [1:0]                   req_operation,
   input  logic signed [COORD_BITS-1:0] req_ctrl1_x,
   input  logic signed [COORD_BITS-1:0] req_ctrl1_y,
   input  logic signed [COORD_BITS-1:0] req_ctrl2_x,
   input  logic signed [COORD_BITS-1:0] req_ctrl2_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS-1:0] rsp_point_x,
   output logic signed [COORD_BITS-1:0] rsp_point_y,
   output logic                         rsp_contour_start,
   output logic                         rsp_last
);

   import opf_pkg::*;

   localparam int C        = COORD_BITS;
   localparam int CMD_BITS = 2 + 8 * C;
   localparam int PT_BITS  = 2 * C + 2;

   // command queue between front and back
   logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_BITS-1:0] cmd_in_data, cmd_out_data;

   // point queue feeding the rsp_ side
   logic               out_push, out_full, out_pop;
   logic [PT_BITS-1:0] out_in_data, out_out_data;

   opf_front #(.COORD_BITS(C)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_ctrl1_x   (req_ctrl1_x),
      .req_ctrl1_y   (req_ctrl1_y),
      .req_ctrl2_x   (req_ctrl2_x),
      .req_ctrl2_y   (req_ctrl2_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_in_data)
   );

   opf_fifo #(.WIDTH(CMD_BITS), .DEPTH(CMD_DEPTH)) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_in_data),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (cmd_out_data),
      .empty (cmd_empty)
   );

   opf_back #(.COORD_BITS(C), .OUT_DEPTH(OUT_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .out_pop   (out_pop),
      .out_push  (out_push),
      .out_data  (out_in_data)
   );

   // the back end only issues against free credits, so this queue never overflows
   opf_fifo #(.WIDTH(PT_BITS), .DEPTH(OUT_DEPTH)) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_in_data),
      .full  (out_full),
      .pop   (out_pop),
      .dout  (out_out_data),
      .empty (rsp_empty)
   );

   assign out_pop           = rsp_pop && !rsp_empty;
   assign rsp_contour_start = out_out_data[PT_BITS-1];
   assign rsp_last          = out_out_data[PT_BITS-2];
   assign rsp_point_x       = out_out_data[2*C-1:C];
   assign rsp_point_y       = out_out_data[C-1:0];

   // a point leaving the pipeline always finds room in the point queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      out_push |-> (!out_full || out_pop))
      else $error("point queue written while full");

   // the back end retires a command only while one is queued
   a_cmd_pop_valid : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command retired from an empty queue");

   // a move point is always the only point of its command
   a_move_single : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_contour_start) |-> rsp_last)
      else $error("contour start point not marked last");

   // after reset both sides come up empty and ready
   a_reset_state : assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not cleared by reset");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for outline_path_flattener (moves, lines, curves)
// depends on opf_pkg and the design; a small scoreboard class predicts every point

module testbench;
   import opf_pkg::*;

   localparam int COORD_BITS = 24;
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;

   // one polyline point as it should appear on the rsp_ side
   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         start;
      logic                         last;
   } polyline_point_type;

   // keeps its own pen and the queue of points still owed by the block
   class polyline_tracker_type;
      longint             pen_x;
      longint             pen_y;
      polyline_point_type expected_points[$];
      int                 mismatch_count;

      function new();
         pen_x = 0;
         pen_y = 0;
         mismatch_count = 0;
      endfunction

      // one de casteljau level at t = k/10, truncated toward zero
      function longint lerp_tenths(longint a, longint b, longint k);
         return (a * (10 - k) + b * k) / 10;
      endfunction

      function longint cubic_point(longint p0, longint p1, longint p2, longint p3,
                                   longint k);
         longint a, b, c, d, e;
         a = lerp_tenths(p0, p1, k);
         b = lerp_tenths(p1, p2, k);
         c = lerp_tenths(p2, p3, k);
         d = lerp_tenths(a, b, k);
         e = lerp_tenths(b, c, k);
         return lerp_tenths(d, e, k);
      endfunction

      function void owe_point(longint x, longint y, logic start, logic last);
         polyline_point_type p;
         p.x = x[COORD_BITS-1:0];
         p.y = y[COORD_BITS-1:0];
         p.start = start;
         p.last = last;
         expected_points.insert(expected_points.size(), p);
      endfunction

      // called for every accepted command beat
      function void take_command(opf_op_type op,
                                 logic signed [COORD_BITS-1:0] c1x,
                                 logic signed [COORD_BITS-1:0] c1y,
                                 logic signed [COORD_BITS-1:0] c2x,
                                 logic signed [COORD_BITS-1:0] c2y,
                                 logic signed [COORD_BITS-1:0] ex,
                                 logic signed [COORD_BITS-1:0] ey);
         longint ax, ay, bx, by, dx, dy, fx, fy;
         ax = longint'(c1x);
         ay = longint'(c1y);
         bx = longint'(c2x);
         by = longint'(c2y);
         fx = longint'(ex);
         fy = longint'(ey);
         case (op)
            OP_MOVE: begin
               owe_point(fx, fy, 1'b1, 1'b1);
            end
            OP_LINE: begin
               owe_point(fx, fy, 1'b0, 1'b1);
            end
            OP_QUAD: begin
               dx = (pen_x + 2 * ax + fx) / 4;
               dy = (pen_y + 2 * ay + fy) / 4;
               owe_point(dx, dy, 1'b0, 1'b0);
               owe_point(fx, fy, 1'b0, 1'b1);
            end
            default: begin
               owe_point(cubic_point(pen_x, ax, bx, fx, longint'(K_EARLY)),
                         cubic_point(pen_y, ay, by, fy, longint'(K_EARLY)), 1'b0, 1'b0);
               owe_point(cubic_point(pen_x, ax, bx, fx, longint'(K_HALF)),
                         cubic_point(pen_y, ay, by, fy, longint'(K_HALF)), 1'b0, 1'b0);
               owe_point(cubic_point(pen_x, ax, bx, fx, longint'(K_LATE)),
                         cubic_point(pen_y, ay, by, fy, longint'(K_LATE)), 1'b0, 1'b0);
               owe_point(fx, fy, 1'b0, 1'b1);
            end
         endcase
         pen_x = fx;
         pen_y = fy;
      endfunction

      // called for every accepted point beat
      function void compare_point(logic signed [COORD_BITS-1:0] x,
                                  logic signed [COORD_BITS-1:0] y,
                                  logic start, logic last);
         polyline_point_type p;
         if (expected_points.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected point x=%0d y=%0d start=%b last=%b",
                     $time, x, y, start, last);
            return;
         end
         p = expected_points.pop_front();
         if (x !== p.x) begin
            mismatch_count++;
            $display("%0t: point_x expected %0d actual %0d", $time, p.x, x);
         end
         if (y !== p.y) begin
            mismatch_count++;
            $display("%0t: point_y expected %0d actual %0d", $time, p.y, y);
         end
         if (start !== p.start) begin
            mismatch_count++;
            $display("%0t: contour_start expected %b actual %b", $time, p.start, start);
         end
         if (last !== p.last) begin
            mismatch_count++;
            $display("%0t: last expected %b actual %b", $time, p.last, last);
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_push;
   logic                         req_full;
   logic [1:0]                   req_operation;
   logic signed [COORD_BITS-1:0] req_ctrl1_x;
   logic signed [COORD_BITS-1:0] req_ctrl1_y;
   logic signed [COORD_BITS-1:0] req_ctrl2_x;
   logic signed [COORD_BITS-1:0] req_ctrl2_y;
   logic signed [COORD_BITS-1:0] req_end_x;
   logic signed [COORD_BITS-1:0] req_end_y;
   logic                         rsp_empty;
   logic                         rsp_pop;
   logic signed [COORD_BITS-1:0] rsp_point_x;
   logic signed [COORD_BITS-1:0] rsp_point_y;
   logic                         rsp_contour_start;
   logic                         rsp_last;

   // idling odds in percent, changed from phase to phase
   int sender_idle_pct;
   int receiver_stall_pct;

   polyline_tracker_type board;

   outline_path_flattener #(.COORD_BITS(COORD_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_operation(req_operation),
      .req_ctrl1_x(req_ctrl1_x),
      .req_ctrl1_y(req_ctrl1_y),
      .req_ctrl2_x(req_ctrl2_x),
      .req_ctrl2_y(req_ctrl2_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y),
      .rsp_contour_start(rsp_contour_start),
      .rsp_last(rsp_last)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // command beats are handed to the predictor at the edge that takes them
   always @(posedge clock) begin
      if (!reset && req_push && !req_full)
         board.take_command(opf_op_type'(req_operation), req_ctrl1_x, req_ctrl1_y,
                            req_ctrl2_x, req_ctrl2_y, req_end_x, req_end_y);
   end

   // point beats are checked at the edge that pops them
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.compare_point(rsp_point_x, rsp_point_y, rsp_contour_start, rsp_last);
   end

   // receiver: pop decided afresh on every falling edge
   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // coordinate with a bias towards the extremes and small values near zero,
   // where truncation toward zero is easiest to get wrong
   function automatic logic signed [COORD_BITS-1:0] random_coord();
      int offset;
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3, 4: begin
            offset = $urandom_range(0, 100);
            return COORD_BITS'(offset - 50);
         end
         default: return COORD_BITS'($urandom());
      endcase
   endfunction

   // one command beat: optional idle gap, then hold push until the block takes it;
   // entered and left at a falling edge
   task automatic send_command(input opf_op_type op,
                               input logic signed [COORD_BITS-1:0] c1x,
                               input logic signed [COORD_BITS-1:0] c1y,
                               input logic signed [COORD_BITS-1:0] c2x,
                               input logic signed [COORD_BITS-1:0] c2y,
                               input logic signed [COORD_BITS-1:0] ex,
                               input logic signed [COORD_BITS-1:0] ey);
      logic taken;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_operation <= op;
      req_ctrl1_x   <= c1x;
      req_ctrl1_y   <= c1y;
      req_ctrl2_x   <= c2x;
      req_ctrl2_y   <= c2y;
      req_end_x     <= ex;
      req_end_y     <= ey;
      do begin
         @(posedge clock);
         taken = !req_full;
         @(negedge clock);
      end while (!taken);
   endtask

   task automatic send_random(input int count);
      opf_op_type op;
      repeat (count) begin
         op = opf_op_type'($urandom_range(0, 3));
         send_command(op, random_coord(), random_coord(), random_coord(),
                      random_coord(), random_coord(), random_coord());
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_operation = OP_MOVE;
      req_ctrl1_x = '0;
      req_ctrl1_y = '0;
      req_ctrl2_x = '0;
      req_ctrl2_y = '0;
      req_end_x = '0;
      req_end_y = '0;
      rsp_pop = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, no idling
      // curves straight after reset start from the origin
      send_command(OP_CUBIC, 100, -100, -37, 53, 7, -9);
      // small negatives: the midpoint must truncate toward zero
      send_command(OP_QUAD, -3, 5, 0, 0, 1, -1);
      // move and line ignore both control points
      send_command(OP_MOVE, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX);
      send_command(OP_LINE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      // quadratic ignores its second control point
      send_command(OP_QUAD, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN);
      send_command(OP_CUBIC, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_command(OP_CUBIC, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_command(OP_MOVE, 0, 0, 0, 0, -1, -1);
      send_command(OP_LINE, -1, -1, -1, -1, 1, 1);
      send_command(OP_QUAD, -2, -2, 0, 0, -1, -1);
      send_command(OP_CUBIC, -11, 13, 17, -19, -23, 29);
      send_command(OP_MOVE, 0, 0, 0, 0, 0, 0);
      send_command(OP_LINE, 0, 0, 0, 0, 0, 0);
      send_command(OP_QUAD, COORD_MIN, COORD_MIN, 0, 0, COORD_MIN, COORD_MIN);
      send_command(OP_CUBIC, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                   COORD_MIN);
      // alternating bit patterns on every coordinate bit
      send_command(OP_LINE, 24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA,
                   24'sh555555, 24'shAAAAAA);
      send_command(OP_CUBIC, 24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA,
                   24'shAAAAAA, 24'sh555555);
      send_command(OP_QUAD, 24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555,
                   24'sh555555, 24'shAAAAAA);

      // random part in four idling phases
      send_random(80);
      sender_idle_pct = 83;
      receiver_stall_pct = 0;
      send_random(80);
      sender_idle_pct = 0;
      receiver_stall_pct = 83;
      send_random(80);
      sender_idle_pct = 19;
      receiver_stall_pct = 19;
      send_random(80);

      req_push <= 1'b0;
      receiver_stall_pct = 0;

      // drain, then give stray points time to show up
      while (board.pending() != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/opf_pkg.sv
design/opf_fifo.sv
design/opf_front.sv
design/opf_lerp.sv
design/opf_back.sv
design/outline_path_flattener.sv
test/testbench.sv
